/* hw/rtl/csfr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csfr_pkg
// Shared types, constants and helpers for the clipped shape-fill rasteriser.
// ----------------------------------------------------------------------------
package csfr_pkg;

    // Store geometry
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Field and datapath widths
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CNV_W     = 9;   // effective canvas size, up to 64
    localparam int POS_W     = 11;  // signed coordinate, covers -255 .. 765
    localparam int K_W       = 9;   // row counter, up to 2*255+1
    localparam int CNT_W     = 13;

    localparam logic [PIX_W-1:0] FILL_CHAR    = 8'd46;
    localparam logic [CNT_W-1:0] COUNT_MAX    = 13'd8191;
    localparam logic [CFG_W-1:0] CANVAS_RESET = 7'd64;

    typedef enum logic [2:0] {
        ACT_CLEAR    = 3'd0,
        ACT_RECT     = 3'd1,
        ACT_TRI_UP   = 3'd2,
        ACT_TRI_DOWN = 3'd3,
        ACT_DIAMOND  = 3'd4,
        ACT_READ     = 3'd5
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CANVAS_ROWS = 2'd0,
        CFG_CANVAS_COLS = 2'd1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ROW,
        ST_SPAN,
        ST_FILL,
        ST_READ,
        ST_RWAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]       action;
        logic [7:0]       anchor_row;
        logic [7:0]       anchor_col;
        logic [7:0]       extent_width;
        logic [7:0]       extent_height;
        logic [PIX_W-1:0] brush;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic [CNT_W-1:0] pixels_written;
    } t_out_item;

    typedef struct packed {
        logic [CNV_W-1:0] rows;
        logic [CNV_W-1:0] cols;
    } t_canvas;

    typedef struct packed {
        logic      done;
        t_out_item item;
    } t_eng_res;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  wdata;
    } t_ram_req;

    function automatic logic [ADDR_W-1:0] pix_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
        pix_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col));
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/clipped_shape_fill_rasterizer_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// clipped_shape_fill_rasterizer_top
// Character framebuffer with clipped rectangle, triangle and diamond fills.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole 64 x 64 store to '.', one pixel a
// cycle, and takes no item until that sweep is done. It then works on one
// item at a time, walking the shape row by row through a single span unit
// and writing one pixel per cycle into the single-port store. Each row of
// the shape, clipped or not, passes a row step and a span step before its
// pixels are written. The result is held in an output register, so the next
// item may be accepted while it waits to be taken.
module clipped_shape_fill_rasterizer_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [csfr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [csfr_pkg::CFG_W-1:0]           i_cfg_data,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire csfr_pkg::t_in_item                   i_in_item,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output csfr_pkg::t_out_item                       o_out_item
);

    logic [csfr_pkg::CFG_W-1:0] r_canvas_rows, r_canvas_cols;
    logic                       r_out_valid;
    csfr_pkg::t_out_item        r_out_item;
    csfr_pkg::t_canvas          canvas;
    csfr_pkg::t_eng_res         eng_res;
    csfr_pkg::t_ram_req         ram_req;
    logic [csfr_pkg::PIX_W-1:0] ram_rdata;
    logic                       out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_rows <= csfr_pkg::CANVAS_RESET;
            r_canvas_cols <= csfr_pkg::CANVAS_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == csfr_pkg::CFG_CANVAS_ROWS) begin
                r_canvas_rows <= i_cfg_data;
            end
            if (i_cfg_idx == csfr_pkg::CFG_CANVAS_COLS) begin
                r_canvas_cols <= i_cfg_data;
            end
        end
    end

    // clip the canvas to the store
    always_comb begin
        canvas.rows = ({2'b00, r_canvas_rows} < csfr_pkg::CNV_W'(csfr_pkg::MAX_ROWS))
                    ? {2'b00, r_canvas_rows} : csfr_pkg::CNV_W'(csfr_pkg::MAX_ROWS);
        canvas.cols = ({2'b00, r_canvas_cols} < csfr_pkg::CNV_W'(csfr_pkg::MAX_COLS))
                    ? {2'b00, r_canvas_cols} : csfr_pkg::CNV_W'(csfr_pkg::MAX_COLS);
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_res.done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_res.done) begin
            r_out_item <= eng_res.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    csfr_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_canvas    (canvas),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .i_out_free  (out_free),
        .o_res       (eng_res),
        .o_ram_req   (ram_req),
        .i_ram_rdata (ram_rdata)
    );

    csfr_ram #(
        .WIDTH (csfr_pkg::PIX_W),
        .DEPTH (csfr_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_addr  (ram_req.addr),
        .i_wdata (ram_req.wdata),
        .o_rdata (ram_rdata)
    );

endmodule
`default_nettype wire

/* hw/rtl/csfr_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csfr_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module csfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule
`default_nettype wire

/* hw/rtl/csfr_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csfr_engine
// Row sequencer: walks the rows of a shape, clips each span to the canvas
// and writes it one pixel a cycle; also runs the clearing pass and reads.
// ----------------------------------------------------------------------------
module csfr_engine (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire csfr_pkg::t_canvas   i_canvas,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire csfr_pkg::t_in_item  i_in_item,
    input  wire logic                i_out_free,
    output csfr_pkg::t_eng_res       o_res,
    output csfr_pkg::t_ram_req       o_ram_req,
    input  wire logic [csfr_pkg::PIX_W-1:0] i_ram_rdata
);

    csfr_pkg::t_state                 r_state, n_state;
    csfr_pkg::t_in_item               r_item, n_item;
    logic [csfr_pkg::K_W-1:0]         r_nrows, n_nrows;
    logic [csfr_pkg::K_W-1:0]         r_k, n_k;
    logic [csfr_pkg::ROW_W-1:0]       r_row, n_row;
    logic                             r_row_ok, n_row_ok;
    logic [7:0]                       r_hw, n_hw;
    logic [csfr_pkg::COL_W-1:0]       r_col, n_col;
    logic [csfr_pkg::COL_W-1:0]       r_c1, n_c1;
    logic [csfr_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic                             r_rd_ok, n_rd_ok;
    logic [csfr_pkg::PIX_W-1:0]       r_value, n_value;
    logic [csfr_pkg::ADDR_W-1:0]      r_init_addr, n_init_addr;

    logic signed [csfr_pkg::POS_W-1:0] k_pos, r_pos, c_pos, w_pos, hw_pos;
    logic signed [csfr_pkg::POS_W-1:0] row_s, c0_s, c1_s, c0_cl, c1_cl, ncm1;
    logic signed [csfr_pkg::POS_W-1:0] nr_pos;
    logic [8:0]                        h_x2;
    logic                              row_ok, span_ok, init_last, rd_ok;

    // ---------------------------------------------------------------------
    // Row and span arithmetic
    // ---------------------------------------------------------------------
    always_comb begin
        k_pos  = $signed({2'b00, r_k});
        r_pos  = $signed({3'b000, r_item.anchor_row});
        c_pos  = $signed({3'b000, r_item.anchor_col});
        w_pos  = $signed({3'b000, r_item.extent_width});
        hw_pos = $signed({3'b000, r_hw});
        nr_pos = $signed({2'b00, i_canvas.rows});
        ncm1   = $signed({2'b00, i_canvas.cols}) - $signed(csfr_pkg::POS_W'(1));
        h_x2   = {r_item.extent_height, 1'b0};

        case (r_item.action)
            csfr_pkg::ACT_CLEAR:    row_s = k_pos;
            csfr_pkg::ACT_TRI_DOWN: row_s = r_pos - k_pos;
            default:                row_s = r_pos + k_pos;
        endcase
        row_ok = !row_s[csfr_pkg::POS_W-1] && (row_s < nr_pos);

        case (r_item.action)
            csfr_pkg::ACT_CLEAR: begin
                c0_s = '0;
                c1_s = ncm1;
            end
            csfr_pkg::ACT_RECT: begin
                c0_s = c_pos;
                c1_s = c_pos + w_pos - $signed(csfr_pkg::POS_W'(1));
            end
            default: begin
                c0_s = c_pos - hw_pos;
                c1_s = c_pos + hw_pos;
            end
        endcase
        c0_cl   = c0_s[csfr_pkg::POS_W-1] ? '0 : c0_s;
        c1_cl   = (c1_s > ncm1) ? ncm1 : c1_s;
        span_ok = r_row_ok && (c0_cl <= c1_cl);

        rd_ok = ({1'b0, r_item.anchor_row} < i_canvas.rows)
             && ({1'b0, r_item.anchor_col} < i_canvas.cols);
        init_last = (r_init_addr == csfr_pkg::ADDR_W'(csfr_pkg::DEPTH - 1));
    end

    // ---------------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            csfr_pkg::ST_INIT: begin
                if (init_last) begin
                    n_state = csfr_pkg::ST_IDLE;
                end
            end
            csfr_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_item.action)
                        csfr_pkg::ACT_CLEAR,
                        csfr_pkg::ACT_RECT,
                        csfr_pkg::ACT_TRI_UP,
                        csfr_pkg::ACT_TRI_DOWN,
                        csfr_pkg::ACT_DIAMOND: n_state = csfr_pkg::ST_ROW;
                        csfr_pkg::ACT_READ:    n_state = csfr_pkg::ST_READ;
                        default:               n_state = csfr_pkg::ST_DONE;
                    endcase
                end
            end
            csfr_pkg::ST_ROW: begin
                n_state = (r_k == r_nrows) ? csfr_pkg::ST_DONE : csfr_pkg::ST_SPAN;
            end
            csfr_pkg::ST_SPAN: begin
                n_state = span_ok ? csfr_pkg::ST_FILL : csfr_pkg::ST_ROW;
            end
            csfr_pkg::ST_FILL: begin
                if (r_col == r_c1) begin
                    n_state = csfr_pkg::ST_ROW;
                end
            end
            csfr_pkg::ST_READ:  n_state = csfr_pkg::ST_RWAIT;
            csfr_pkg::ST_RWAIT: n_state = csfr_pkg::ST_DONE;
            csfr_pkg::ST_DONE: begin
                if (i_out_free) begin
                    n_state = csfr_pkg::ST_IDLE;
                end
            end
            default: n_state = csfr_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // Outputs
    // ---------------------------------------------------------------------
    always_comb begin
        o_in_ready    = 1'b0;
        o_ram_req     = '0;
        o_res.done    = 1'b0;
        o_res.item.pixel_value    = r_value;
        o_res.item.pixels_written = r_cnt;
        case (r_state)
            csfr_pkg::ST_INIT: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.addr  = r_init_addr;
                o_ram_req.wdata = csfr_pkg::FILL_CHAR;
            end
            csfr_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            csfr_pkg::ST_FILL: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.addr  = csfr_pkg::pix_addr(r_row, r_col);
                o_ram_req.wdata = (r_item.action == csfr_pkg::ACT_CLEAR)
                                ? csfr_pkg::FILL_CHAR : r_item.brush;
            end
            csfr_pkg::ST_READ: begin
                o_ram_req.addr = csfr_pkg::pix_addr(
                    r_item.anchor_row[csfr_pkg::ROW_W-1:0],
                    r_item.anchor_col[csfr_pkg::COL_W-1:0]);
            end
            csfr_pkg::ST_DONE: begin
                o_res.done = i_out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Datapath next values
    // ---------------------------------------------------------------------
    always_comb begin
        n_item      = r_item;
        n_nrows     = r_nrows;
        n_k         = r_k;
        n_row       = r_row;
        n_row_ok    = r_row_ok;
        n_hw        = r_hw;
        n_col       = r_col;
        n_c1        = r_c1;
        n_cnt       = r_cnt;
        n_rd_ok     = r_rd_ok;
        n_value     = r_value;
        n_init_addr = r_init_addr;
        case (r_state)
            csfr_pkg::ST_INIT: begin
                n_init_addr = r_init_addr + 1'b1;
            end
            csfr_pkg::ST_IDLE: begin
                n_item  = i_in_item;
                n_k     = '0;
                n_cnt   = '0;
                n_value = '0;
                case (i_in_item.action)
                    csfr_pkg::ACT_CLEAR:   n_nrows = i_canvas.rows;
                    csfr_pkg::ACT_DIAMOND: n_nrows = {i_in_item.extent_height, 1'b1};
                    default:               n_nrows = {1'b0, i_in_item.extent_height};
                endcase
            end
            csfr_pkg::ST_ROW: begin
                n_row    = row_s[csfr_pkg::ROW_W-1:0];
                n_row_ok = row_ok;
                // lower half of a diamond narrows again
                if (r_item.action == csfr_pkg::ACT_DIAMOND
                        && r_k > {1'b0, r_item.extent_height}) begin
                    n_hw = 8'(h_x2 - r_k);
                end else begin
                    n_hw = r_k[7:0];
                end
            end
            csfr_pkg::ST_SPAN: begin
                n_col = c0_cl[csfr_pkg::COL_W-1:0];
                n_c1  = c1_cl[csfr_pkg::COL_W-1:0];
                if (!span_ok) begin
                    n_k = r_k + 1'b1;
                end
            end
            csfr_pkg::ST_FILL: begin
                n_col = r_col + 1'b1;
                n_cnt = (r_cnt == csfr_pkg::COUNT_MAX) ? r_cnt : r_cnt + 1'b1;
                if (r_col == r_c1) begin
                    n_k = r_k + 1'b1;
                end
            end
            csfr_pkg::ST_READ: begin
                n_rd_ok = rd_ok;
            end
            csfr_pkg::ST_RWAIT: begin
                n_value = r_rd_ok ? i_ram_rdata : '0;
            end
            default: begin
                n_k = r_k;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= csfr_pkg::ST_INIT;
            r_init_addr <= '0;
        end else begin
            r_state     <= n_state;
            r_init_addr <= n_init_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_nrows  <= n_nrows;
        r_k      <= n_k;
        r_row    <= n_row;
        r_row_ok <= n_row_ok;
        r_hw     <= n_hw;
        r_col    <= n_col;
        r_c1     <= n_c1;
        r_cnt    <= n_cnt;
        r_rd_ok  <= n_rd_ok;
        r_value  <= n_value;
    end

endmodule
`default_nettype wire

/* hw/rtl/csfr_chk.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csfr_chk
// Port-level checks for the clipped shape-fill rasteriser.
// ----------------------------------------------------------------------------
module csfr_chk (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_cfg_we,
    input wire logic [csfr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input wire logic [csfr_pkg::CFG_W-1:0]     i_cfg_data,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_ready,
    input wire csfr_pkg::t_in_item             i_in_item,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_ready,
    input wire csfr_pkg::t_out_item            o_out_item
);

    // clearing pass keeps the input closed right after reset
    a_init_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("block open for items straight after reset");

    // one item at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item accepted while one is in progress");

    // no shape covers a pixel twice, so a count never exceeds the store
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.pixels_written
                        <= csfr_pkg::CNT_W'(csfr_pkg::DEPTH))
        else $error("pixel count larger than the store");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_item))
        else $error("stalled result changed");

endmodule

bind clipped_shape_fill_rasterizer_top csfr_chk u_csfr_chk (.*);
`default_nettype wire
